/* design/bffa_pkg.sv */
`timescale 1ns / 1ps
package bffa_pkg;

  localparam int NUM_W     = 11;
  localparam int KIND_W    = 3;
  localparam int SLOT_W    = 7;
  localparam int BYTE_W    = 8;
  localparam int BIDX_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [NUM_W-1:0] FIRST_USABLE_RST = 11'd11;
  localparam logic [NUM_W-1:0] TOTAL_COUNT_RST  = 11'd1024;
  localparam logic [NUM_W-1:0] COUNT_MAX        = 11'd2047;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_LOAD  = 3'd0;
  localparam kind_t KIND_ALLOC = 3'd1;
  localparam kind_t KIND_SET   = 3'd2;
  localparam kind_t KIND_CLEAR = 3'd3;
  localparam kind_t KIND_TEST  = 3'd4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FIRST_USABLE = 1'd0;
  localparam cfg_idx_t CFG_TOTAL_COUNT  = 1'd1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_SPACE  = 2'd1,
    STATUS_NO_EFFECT = 2'd2,
    STATUS_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage

/* design/bffa_in_if.sv */
`timescale 1ns / 1ps
interface bffa_in_if;
  import bffa_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [NUM_W-1:0]  number;
  logic [SLOT_W-1:0] byte_slot;
  logic [BYTE_W-1:0] byte_value;

  modport source(output valid, kind, number, byte_slot, byte_value, input ready);
  modport sink(input valid, kind, number, byte_slot, byte_value, output ready);
endinterface

/* design/bffa_out_if.sv */
`timescale 1ns / 1ps
interface bffa_out_if;
  import bffa_pkg::*;

  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] result_number;
  status_t          status;
  logic             bit_value;
  logic [NUM_W-1:0] free_count;

  modport source(output valid, result_number, status, bit_value, free_count, input ready);
  modport sink(input valid, result_number, status, bit_value, free_count, output ready);
endinterface

/* design/bffa_ram.sv */
`timescale 1ns / 1ps
module bffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/bitmap_first_free_allocator_core.sv */
`timescale 1ns / 1ps
// Load, set, clear and test: accepted, then an evaluate state, then a response state
// that loads the output register once it is free; no new item is taken meanwhile.
// Rejected items skip the evaluate state. Allocate: k bitmap bytes scanned, one byte per
// cycle through the single RAM port; at most NUM_BITS/8 bytes.
// Reset (synchronous, rst_n low): registers to defaults, free count zero, then a
// clearing pass writes zero to all NUM_BITS/8 bytes, one per cycle, before input is taken.
module bitmap_first_free_allocator_core #(
  parameter int NUM_BITS = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bffa_in_if.sink                      in_ch,
  bffa_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [bffa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bffa_pkg::NUM_W-1:0]   cfg_wdata
);
  import bffa_pkg::*;

  localparam int MAP_BYTES = (NUM_BITS + 7) / 8;
  localparam int AW = MAP_BYTES > 1 ? $clog2(MAP_BYTES) : 1;
  localparam int IW = AW > BIDX_W ? AW : BIDX_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

  state_t state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  kind_t             kind_r, kind_nxt;
  logic [AW-1:0]     op_addr_r, op_addr_nxt;
  logic [2:0]        op_bit_r, op_bit_nxt;
  logic [SLOT_W-1:0] op_slot_r, op_slot_nxt;
  logic [BYTE_W-1:0] op_val_r, op_val_nxt;
  logic [BIDX_W-1:0] scan_byte_r, scan_byte_nxt;
  logic [2:0]        scan_off_r, scan_off_nxt;
  logic [NUM_W-1:0]  res_num_r, res_num_nxt;
  status_t           status_r, status_nxt;
  logic              bit_r, bit_nxt;
  logic [NUM_W-1:0]  free_r, free_nxt;
  logic [NUM_W-1:0]  first_usable_r, first_usable_nxt;
  logic [NUM_W-1:0]  total_count_r, total_count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0]  out_num_r, out_num_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_bit_r, out_bit_nxt;
  logic [NUM_W-1:0]  out_free_r, out_free_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;

  logic [NUM_W-1:0]  tot;
  logic              acc;
  logic              out_free_slot;
  logic [NUM_W-1:0]  num_m1;
  logic              num_in_range;
  logic              slot_ok;
  logic [NUM_W-1:0]  alloc_n0;
  logic [NUM_W-1:0]  alloc_m1;
  logic              alloc_empty;

  logic [7:0]        cand;
  logic              found;
  logic [2:0]        found_bit;
  logic [BIDX_W:0]   next_byte;
  logic [NUM_W:0]    next_first;
  logic              scan_end;

  logic              cur_bit;
  logic [BYTE_W-1:0] op_mask;
  logic [3:0]        old_clear;
  logic [3:0]        new_clear;
  logic [NUM_W-1:0]  load_sub;
  logic [NUM_W:0]    load_sum;
  logic [NUM_W-1:0]  load_free;
  logic [NUM_W-1:0]  free_dec;
  logic [NUM_W-1:0]  free_inc;

  function automatic logic [AW-1:0] byte_addr(logic [BIDX_W-1:0] b);
    logic [IW-1:0] e;
    e = IW'(b);
    return e[AW-1:0];
  endfunction

  bffa_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAP_BYTES)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign tot = (32'(total_count_r) < NUM_BITS) ? total_count_r : NUM_W'(NUM_BITS);
  assign in_ch.ready   = (state_r == ST_IDLE);
  assign acc           = in_ch.valid && in_ch.ready;
  assign out_free_slot = !out_valid_r || out_ch.ready;

  assign num_m1       = in_ch.number - 11'd1;
  assign num_in_range = (in_ch.number != '0) && (in_ch.number <= tot);
  assign slot_ok      = 32'(in_ch.byte_slot) < MAP_BYTES;
  assign alloc_n0     = (first_usable_r == '0) ? 11'd1 : first_usable_r;
  assign alloc_m1     = alloc_n0 - 11'd1;
  assign alloc_empty  = (free_r == '0) || (alloc_n0 > tot);

  always_comb begin
    logic [NUM_W:0] num_b;
    for (int b = 0; b < 8; b++) begin
      num_b = {1'b0, scan_byte_r, 3'(b)} + 12'd1;
      cand[b] = !ram_rdata[b] && (3'(b) >= scan_off_r) && (num_b <= {1'b0, tot});
    end
    found     = 1'b0;
    found_bit = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (cand[b]) begin
        found     = 1'b1;
        found_bit = 3'(b);
      end
    end
  end

  assign next_byte  = {1'b0, scan_byte_r} + 9'd1;
  assign next_first = {next_byte, 3'b000} + 12'd1;
  assign scan_end   = next_first > {1'b0, tot};

  assign cur_bit = ram_rdata[op_bit_r];
  assign op_mask = 8'd1 << op_bit_r;

  always_comb begin
    logic [NUM_W:0] lim;
    old_clear = '0;
    new_clear = '0;
    for (int b = 0; b < 8; b++) begin
      lim = {2'b00, op_slot_r, 3'(b)};
      if (lim < {1'b0, tot}) begin
        old_clear = old_clear + {3'b000, !ram_rdata[b]};
        new_clear = new_clear + {3'b000, !op_val_r[b]};
      end
    end
  end

  assign load_sub  = (free_r > NUM_W'(old_clear)) ? free_r - NUM_W'(old_clear) : '0;
  assign load_sum  = {1'b0, load_sub} + 12'(new_clear);
  assign load_free = (load_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : load_sum[NUM_W-1:0];
  assign free_dec  = (free_r == '0) ? free_r : free_r - 11'd1;
  assign free_inc  = (free_r == COUNT_MAX) ? free_r : free_r + 11'd1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          unique case (in_ch.kind)
            KIND_LOAD:  state_nxt = slot_ok ? ST_EVAL : ST_RESP;
            KIND_ALLOC: state_nxt = alloc_empty ? ST_RESP : ST_SCAN;
            KIND_SET, KIND_CLEAR, KIND_TEST: state_nxt = num_in_range ? ST_EVAL : ST_RESP;
            default:    state_nxt = ST_RESP;
          endcase
        end
      end
      ST_EVAL: state_nxt = ST_RESP;
      ST_SCAN: begin
        if (found || scan_end) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free_slot) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_addr_nxt     = clr_addr_r;
    kind_nxt         = kind_r;
    op_addr_nxt      = op_addr_r;
    op_bit_nxt       = op_bit_r;
    op_slot_nxt      = op_slot_r;
    op_val_nxt       = op_val_r;
    scan_byte_nxt    = scan_byte_r;
    scan_off_nxt     = scan_off_r;
    res_num_nxt      = res_num_r;
    status_nxt       = status_r;
    bit_nxt          = bit_r;
    free_nxt         = free_r;
    first_usable_nxt = first_usable_r;
    total_count_nxt  = total_count_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_num_nxt      = out_num_r;
    out_status_nxt   = out_status_r;
    out_bit_nxt      = out_bit_r;
    out_free_nxt     = out_free_r;
    ram_we           = 1'b0;
    ram_addr         = op_addr_r;
    ram_wdata        = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_USABLE: first_usable_nxt = cfg_wdata;
        CFG_TOTAL_COUNT:  total_count_nxt  = cfg_wdata;
      endcase
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      ST_IDLE: begin
        if (acc) begin
          kind_nxt    = in_ch.kind;
          op_bit_nxt  = num_m1[2:0];
          op_slot_nxt = in_ch.byte_slot;
          op_val_nxt  = in_ch.byte_value;
          res_num_nxt = '0;
          bit_nxt     = 1'b0;
          status_nxt  = STATUS_OK;
          unique case (in_ch.kind)
            KIND_LOAD: begin
              op_addr_nxt = byte_addr(BIDX_W'(in_ch.byte_slot));
              if (!slot_ok) begin
                status_nxt = STATUS_RANGE;
              end
            end
            KIND_ALLOC: begin
              op_addr_nxt   = byte_addr(alloc_m1[NUM_W-1:3]);
              scan_byte_nxt = alloc_m1[NUM_W-1:3];
              scan_off_nxt  = alloc_m1[2:0];
              if (alloc_empty) begin
                status_nxt = STATUS_NO_SPACE;
              end
            end
            KIND_SET, KIND_CLEAR, KIND_TEST: begin
              op_addr_nxt = byte_addr(num_m1[NUM_W-1:3]);
              if (!num_in_range) begin
                status_nxt = STATUS_RANGE;
              end
            end
            default: status_nxt = STATUS_NO_EFFECT;
          endcase
          ram_addr = op_addr_nxt;
        end
      end
      ST_EVAL: begin
        unique case (kind_r)
          KIND_LOAD: begin
            ram_we    = 1'b1;
            ram_wdata = op_val_r;
            free_nxt  = load_free;
          end
          KIND_SET: begin
            bit_nxt = 1'b1;
            if (cur_bit) begin
              status_nxt = STATUS_NO_EFFECT;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata | op_mask;
              free_nxt  = free_dec;
            end
          end
          KIND_CLEAR: begin
            if (!cur_bit) begin
              status_nxt = STATUS_NO_EFFECT;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata & ~op_mask;
              free_nxt  = free_inc;
            end
          end
          KIND_TEST: bit_nxt = cur_bit;
          default:   status_nxt = STATUS_NO_EFFECT;
        endcase
      end
      ST_SCAN: begin
        priority if (found) begin
          ram_we      = 1'b1;
          ram_addr    = byte_addr(scan_byte_r);
          ram_wdata   = ram_rdata | (8'd1 << found_bit);
          res_num_nxt = {scan_byte_r, found_bit} + 11'd1;
          free_nxt    = free_dec;
          status_nxt  = STATUS_OK;
          bit_nxt     = 1'b1;
        end else if (scan_end) begin
          status_nxt = STATUS_NO_SPACE;
        end else begin
          scan_byte_nxt = next_byte[BIDX_W-1:0];
          scan_off_nxt  = 3'd0;
          ram_addr      = byte_addr(next_byte[BIDX_W-1:0]);
        end
      end
      ST_RESP: begin
        if (out_free_slot) begin
          out_valid_nxt  = 1'b1;
          out_num_nxt    = res_num_r;
          out_status_nxt = status_r;
          out_bit_nxt    = bit_r;
          out_free_nxt   = free_r;
        end
      end
      default: ram_addr = op_addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      free_r         <= '0;
      first_usable_r <= FIRST_USABLE_RST;
      total_count_r  <= TOTAL_COUNT_RST;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_addr_r     <= clr_addr_nxt;
      free_r         <= free_nxt;
      first_usable_r <= first_usable_nxt;
      total_count_r  <= total_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    op_addr_r    <= op_addr_nxt;
    op_bit_r     <= op_bit_nxt;
    op_slot_r    <= op_slot_nxt;
    op_val_r     <= op_val_nxt;
    scan_byte_r  <= scan_byte_nxt;
    scan_off_r   <= scan_off_nxt;
    res_num_r    <= res_num_nxt;
    status_r     <= status_nxt;
    bit_r        <= bit_nxt;
    out_num_r    <= out_num_nxt;
    out_status_r <= out_status_nxt;
    out_bit_r    <= out_bit_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_number = out_num_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.bit_value     = out_bit_r;
  assign out_ch.free_count    = out_free_r;

`ifndef NO_ASSERTIONS
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("bitmap written while idle");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_ch.ready)
    else $error("input taken again before result formed");

  a_no_space_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == STATUS_NO_SPACE) |->
      (out_ch.result_number == '0 && !out_ch.bit_value))
    else $error("no-space result carries a number or bit");

  a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.result_number != '0) |->
      (out_ch.status == STATUS_OK && out_ch.bit_value))
    else $error("allocated number without ok status and set bit");
`endif

endmodule

/* verif/bffa_alloc_checker.sv */
`timescale 1ns / 1ps
module bffa_alloc_checker #(
  parameter int MAP_BITS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bffa_in_if                             in_mon,
  bffa_out_if                            out_mon,
  input  logic                           cfg_we,
  input  logic [bffa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bffa_pkg::NUM_W-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             pending
);
  import bffa_pkg::*;

  localparam int MAP_BYTES = MAP_BITS / 8;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    status_t          status;
    logic             bit_value;
    logic [NUM_W-1:0] free_count;
  } alloc_result_t;

  logic [BYTE_W-1:0] map_bytes [MAP_BYTES];
  logic [NUM_W-1:0]  free_cnt;
  logic [NUM_W-1:0]  first_usable;
  logic [NUM_W-1:0]  total_count;
  alloc_result_t     expected_results [$];
  int                fails = 0;

  function automatic logic stored_bit(int n);
    return map_bytes[(n - 1) / 8][(n - 1) % 8];
  endfunction

  function automatic void write_bit(int n, logic v);
    map_bytes[(n - 1) / 8][(n - 1) % 8] = v;
  endfunction

  function automatic int clear_count(int slot, logic [BYTE_W-1:0] val, int tot);
    int c;
    c = 0;
    for (int b = 0; b < 8; b++) begin
      if (slot * 8 + b < tot && !val[b]) c++;
    end
    return c;
  endfunction

  function automatic alloc_result_t predict_alloc_result(kind_t kind, logic [NUM_W-1:0] num,
                                                         logic [SLOT_W-1:0] slot,
                                                         logic [BYTE_W-1:0] val);
    alloc_result_t r;
    int            tot;
    int            n;
    int            cnt;
    logic          in_range;
    logic          found;
    tot = (int'(total_count) < MAP_BITS) ? int'(total_count) : MAP_BITS;
    in_range = (int'(num) >= 1) && (int'(num) <= tot);
    r = '0;
    r.status = STATUS_OK;
    case (kind)
      KIND_LOAD: begin
        if (int'(slot) >= MAP_BYTES) begin
          r.status = STATUS_RANGE;
        end else begin
          cnt = int'(free_cnt) - clear_count(int'(slot), map_bytes[slot], tot);
          if (cnt < 0) cnt = 0;
          cnt += clear_count(int'(slot), val, tot);
          free_cnt = (cnt > int'(COUNT_MAX)) ? COUNT_MAX : NUM_W'(cnt);
          map_bytes[slot] = val;
        end
      end
      KIND_ALLOC: begin
        r.status = STATUS_NO_SPACE;
        found = 1'b0;
        if (free_cnt != '0) begin
          n = (int'(first_usable) < 1) ? 1 : int'(first_usable);
          for (; n <= tot && !found; n++) begin
            if (!stored_bit(n)) begin
              write_bit(n, 1'b1);
              free_cnt = free_cnt - 11'd1;
              r.number = NUM_W'(n);
              r.status = STATUS_OK;
              r.bit_value = 1'b1;
              found = 1'b1;
            end
          end
        end
      end
      KIND_SET: begin
        if (!in_range) begin
          r.status = STATUS_RANGE;
        end else begin
          r.bit_value = 1'b1;
          if (stored_bit(int'(num))) begin
            r.status = STATUS_NO_EFFECT;
          end else begin
            write_bit(int'(num), 1'b1);
            if (free_cnt != '0) free_cnt = free_cnt - 11'd1;
          end
        end
      end
      KIND_CLEAR: begin
        if (!in_range) begin
          r.status = STATUS_RANGE;
        end else if (!stored_bit(int'(num))) begin
          r.status = STATUS_NO_EFFECT;
        end else begin
          write_bit(int'(num), 1'b0);
          if (free_cnt != COUNT_MAX) free_cnt = free_cnt + 11'd1;
        end
      end
      KIND_TEST: begin
        if (!in_range) begin
          r.status = STATUS_RANGE;
        end else begin
          r.bit_value = stored_bit(int'(num));
        end
      end
      default: begin
        r.status = STATUS_NO_EFFECT;
      end
    endcase
    r.free_count = free_cnt;
    return r;
  endfunction

  task automatic compare_field(string field, logic [NUM_W-1:0] want, logic [NUM_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      foreach (map_bytes[i]) map_bytes[i] = '0;
      free_cnt = '0;
      first_usable = FIRST_USABLE_RST;
      total_count = TOTAL_COUNT_RST;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_USABLE: first_usable = cfg_wdata;
          CFG_TOTAL_COUNT:  total_count = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_results.push_back(predict_alloc_result(in_mon.kind, in_mon.number,
                                                        in_mon.byte_slot, in_mon.byte_value));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected: number %0d status %0d bit %0b free %0d",
                   $time, out_mon.result_number, out_mon.status, out_mon.bit_value,
                   out_mon.free_count);
          fails++;
        end else begin
          want = expected_results.pop_front();
          compare_field("result_number", want.number, out_mon.result_number);
          compare_field("status", NUM_W'(want.status), NUM_W'(out_mon.status));
          compare_field("bit_value", NUM_W'(want.bit_value), NUM_W'(out_mon.bit_value));
          compare_field("free_count", want.free_count, out_mon.free_count);
        end
      end
    end
    fail_count <= fails;
    pending <= expected_results.size();
  end

endmodule

/* verif/bitmap_first_free_allocator_core_test.sv */
`timescale 1ns / 1ps
module bitmap_first_free_allocator_core_test;
  import bffa_pkg::*;

  localparam int NUM_BITS    = 1024;
  localparam int CYCLE_LIMIT = 2000000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NUM_W-1:0]     cfg_wdata;
  logic                 out_ready = 1'b0;
  int                   fail_count;
  int                   pending;
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int                   cur_total = NUM_BITS;
  int                   cycles = 0;

  bffa_in_if  in_ch ();
  bffa_out_if out_ch ();

  assign out_ch.ready = out_ready;

  bitmap_first_free_allocator_core #(
    .NUM_BITS(NUM_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  bffa_alloc_checker #(
    .MAP_BITS(NUM_BITS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= (32'($urandom_range(99)) >= 32'(stall_pct));
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(kind_t kind, int num, int slot, int val);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.number     <= NUM_W'(num);
    in_ch.byte_slot  <= SLOT_W'(slot);
    in_ch.byte_value <= BYTE_W'(val);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold off until every outstanding result has transferred
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_regs(int first, int total);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_USABLE;
    cfg_wdata <= NUM_W'(first);
    @(posedge clk);
    cfg_index <= CFG_TOTAL_COUNT;
    cfg_wdata <= NUM_W'(total);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_total = (total < NUM_BITS) ? total : NUM_BITS;
  endtask

  function automatic int pick_number();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(cur_total, 1);
    if (r < 88) return 0;
    if (r < 95 && cur_total < NUM_BITS) return $urandom_range(NUM_BITS, cur_total + 1);
    return $urandom_range(1) ? NUM_BITS : 1;
  endfunction

  function automatic int pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'hFF;
    if (r < 60) return 0;
    if (r < 80) return 8'hFF ^ (1 << $urandom_range(7));
    return $urandom_range(255);
  endfunction

  // load one value into a run of slots under a given total
  task automatic sweep_slots(int total, int last_slot, int val);
    wait_drained();
    write_regs(1, total);
    for (int s = 1; s <= last_slot; s++) send_item(KIND_LOAD, $urandom, s, val);
  endtask

  // fill the map except one slot, then allocate from what is left
  task automatic fill_map_leave_hole(output int sent);
    int slots;
    int hole;
    int n_alloc;
    slots = (cur_total + 7) / 8;
    hole = $urandom_range(slots - 1);
    n_alloc = $urandom_range(4, 1);
    for (int s = 0; s < slots; s++) begin
      if (s != hole) send_item(KIND_LOAD, $urandom, s, 8'hFF);
    end
    send_item(KIND_LOAD, $urandom, hole, $urandom_range(254));
    repeat (n_alloc) send_item(KIND_ALLOC, $urandom, $urandom, $urandom);
    sent = slots + n_alloc;
  endtask

  task automatic run_mix(int count);
    int done;
    int r;
    int len;
    int slot;
    int sent;
    done = 0;
    while (done < count) begin
      r = $urandom_range(39);
      if (r == 0) begin
        fill_map_leave_hole(sent);
        done += sent;
      end else if (r < 14) begin
        slot = $urandom_range((cur_total + 7) / 8 - 1);
        len = $urandom_range(12, 1);
        for (int i = 0; i < len; i++) begin
          send_item(KIND_LOAD, $urandom, (slot + i) % (NUM_BITS / 8), pick_byte());
        end
        done += len;
      end else if (r < 26) begin
        len = $urandom_range(8, 1);
        repeat (len) send_item(KIND_ALLOC, $urandom, $urandom, $urandom);
        done += len;
      end else begin
        case ($urandom_range(3))
          0: send_item(KIND_SET, pick_number(), $urandom, $urandom);
          1: send_item(KIND_CLEAR, pick_number(), $urandom, $urandom);
          2: send_item(KIND_TEST, pick_number(), $urandom, $urandom);
          default: send_item(KIND_LOAD, $urandom, $urandom, pick_byte());
        endcase
        done++;
      end
    end
  endtask

  initial begin
    int sent;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_LOAD;
    in_ch.number     <= '0;
    in_ch.byte_slot  <= '0;
    in_ch.byte_value <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_FIRST_USABLE;
    cfg_wdata        <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: counter starts at zero
    send_item(KIND_ALLOC, 0, 0, 0);
    send_item(KIND_SET, 3, 0, 0);
    send_item(KIND_TEST, 3, 0, 0);
    send_item(KIND_TEST, 0, 0, 0);
    send_item(KIND_SET, 0, 0, 0);
    send_item(KIND_CLEAR, 0, 0, 0);
    send_item(KIND_TEST, NUM_BITS, 0, 0);
    send_item(KIND_CLEAR, 3, 0, 0);
    send_item(KIND_CLEAR, 3, 0, 0);
    send_item(KIND_SET, NUM_BITS, 0, 0);
    send_item(KIND_SET, NUM_BITS, 0, 0);
    send_item(KIND_LOAD, 0, 0, 8'h00);
    send_item(KIND_LOAD, 0, 1, 8'hFF);
    send_item(KIND_LOAD, 0, 2, 8'h00);
    send_item(KIND_LOAD, 0, 127, 8'h55);
    send_item(KIND_ALLOC, 0, 0, 0);
    send_item(KIND_ALLOC, 0, 0, 0);
    send_item(KIND_TEST, 17, 0, 0);

    // smallest map, lowest first usable
    wait_drained();
    write_regs(1, 8);
    send_item(KIND_TEST, 9, 0, 0);
    send_item(KIND_SET, NUM_BITS, 0, 0);
    send_item(KIND_ALLOC, 0, 0, 0);
    send_item(KIND_LOAD, 0, 0, 8'hFF);
    send_item(KIND_ALLOC, 0, 0, 0);
    send_item(KIND_LOAD, 0, 0, 8'h00);

    // only the top number is usable
    wait_drained();
    write_regs(NUM_BITS, NUM_BITS);
    send_item(KIND_LOAD, 0, 127, 8'h7F);
    send_item(KIND_ALLOC, 0, 0, 0);
    send_item(KIND_ALLOC, 0, 0, 0);

    // drive the free count into saturation by toggling the tracked total
    sweep_slots(8, 127, 8'hFF);
    sweep_slots(NUM_BITS, 127, 8'h00);
    sweep_slots(8, 127, 8'hFF);
    sweep_slots(NUM_BITS, 127, 8'h00);
    sweep_slots(8, 4, 8'hFF);
    sweep_slots(NUM_BITS, 4, 8'h00);

    wait_drained();
    write_regs(11, NUM_BITS);
    run_mix(80);

    wait_drained();
    idle_pct = 76;
    write_regs($urandom_range(NUM_BITS, 1), NUM_BITS);
    fill_map_leave_hole(sent);
    run_mix(80);

    wait_drained();
    idle_pct = 0;
    stall_pct <= 76;
    write_regs($urandom_range(64, 1), $urandom_range(NUM_BITS, 8));
    run_mix(80);

    wait_drained();
    idle_pct = 14;
    stall_pct <= 14;
    write_regs(1, $urandom_range(NUM_BITS, 8));
    fill_map_leave_hole(sent);
    run_mix(80);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* bitmap_first_free_allocator_core.f */
design/bffa_pkg.sv
design/bffa_in_if.sv
design/bffa_out_if.sv
design/bffa_ram.sv
design/bitmap_first_free_allocator_core.sv
verif/bffa_alloc_checker.sv
verif/bitmap_first_free_allocator_core_test.sv
